>>> hdl/usos_pkg.sv
// shared types, widths and register codes of the sphere-union level value core
package usos_pkg;

  localparam int MAX_BALLS_DEF = 16;
  localparam int COORD_BITS    = 16;
  localparam int RADIUS_BITS   = 15;
  localparam int LEVEL_BITS    = 18;
  localparam int SQ_W          = 2 * COORD_BITS;
  localparam int SUM_W         = SQ_W + 2;
  localparam int ROOT_W        = COORD_BITS + 1;

  localparam logic signed [LEVEL_BITS-1:0] LEVEL_MOST_NEG =
    {1'b1, {(LEVEL_BITS-1){1'b0}}};

  // register select bit of the configuration address
  localparam logic REG_BALL_COUNT = 1'b0;

  // item operation codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  typedef struct packed {
    logic [RADIUS_BITS-1:0]       radius;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } ball_t;

  typedef struct packed {
    logic                   vld;
    logic                   last;
    logic [RADIUS_BITS-1:0] radius;
  } pipe_ctl_t;

  typedef struct packed {
    pipe_ctl_t         ctl;
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } root_t;

endpackage

>>> hdl/union_of_spheres_level_value_core.sv
// top level: ball table chain, distance pipeline and max accumulator
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  op, ball_index, radius, x/y/z_coord
// out_      output     out_valid/out_stall  level_value, empty_flag
// cfg_      input      apb psel/penable     ball_count at byte address 0
//
// a load item writes one cell of the ball chain
// an evaluate item rotates the chain through one full turn, one ball a cycle into the
// distance pipeline, then drains through the difference, square, sum and root stages
// the chain rotation and the drain set the per-item cost; one item is worked at a time
// reset clears control only; ball cells hold whatever was last loaded
// the result waits in the output register; a new item is taken meanwhile
module union_of_spheres_level_value_core #(
  parameter int MAX_BALLS = usos_pkg::MAX_BALLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [3:0]                            in_ball_index,
  input  logic [usos_pkg::RADIUS_BITS-1:0]      in_radius,
  input  logic signed [usos_pkg::COORD_BITS-1:0] in_x_coord,
  input  logic signed [usos_pkg::COORD_BITS-1:0] in_y_coord,
  input  logic signed [usos_pkg::COORD_BITS-1:0] in_z_coord,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [usos_pkg::LEVEL_BITS-1:0] out_level_value,
  output logic                                  out_empty_flag,
  // configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [2:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import usos_pkg::*;

  localparam int IDX_W = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(MAX_BALLS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ROTATE = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [4:0] ball_count_r;

  // evaluate point, held for the rotation
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;

  // ------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_BALL_COUNT) ? {27'b0, ball_count_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_count_r <= 5'd1;
    end else if (cfg_wr && cfg_paddr[2] == REG_BALL_COUNT) begin
      ball_count_r <= cfg_pwdata[4:0];
    end
  end

  // balls actually used, clamped to the table size
  logic [8:0] bc_ext, n_eff;
  assign bc_ext = {4'b0, ball_count_r};
  assign n_eff  = (bc_ext > 9'(MAX_BALLS)) ? 9'(MAX_BALLS) : bc_ext;

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  logic in_fire, load_fire, eval_fire;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid & ~in_stall;
  assign load_fire = in_fire & ~in_op;
  assign eval_fire = in_fire & in_op;

  // ------------------------------------------------------------------
  // ball chain: cell 0 is the head, rotation moves every entry one place down
  // ------------------------------------------------------------------
  ball_t balls [MAX_BALLS];
  ball_t load_ball;
  logic  rotating;

  assign rotating = (state_r == ST_ROTATE);
  assign load_ball = '{radius: in_radius, x: in_x_coord, y: in_y_coord, z: in_z_coord};

  for (genvar i = 0; i < MAX_BALLS; i++) begin : g_ball
    localparam int NX = (i + 1) % MAX_BALLS;
    usos_ball_cell u_cell (
      .clk       (clk),
      .load_en   (load_fire && (9'(in_ball_index) == 9'(i))),
      .shift_en  (rotating),
      .load_ball (load_ball),
      .next_ball (balls[NX]),
      .ball      (balls[i])
    );
  end

  // ------------------------------------------------------------------
  // stage a: absolute coordinate differences
  // ------------------------------------------------------------------
  pipe_ctl_t ctl_a_r, ctl_b_r, ctl_c_r;
  logic [COORD_BITS-1:0] ax_r, ay_r, az_r;
  logic signed [COORD_BITS:0] dx, dy, dz;

  assign dx = (COORD_BITS+1)'(px_r) - (COORD_BITS+1)'(balls[0].x);
  assign dy = (COORD_BITS+1)'(py_r) - (COORD_BITS+1)'(balls[0].y);
  assign dz = (COORD_BITS+1)'(pz_r) - (COORD_BITS+1)'(balls[0].z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.vld  <= 1'b0;
      ctl_a_r.last <= 1'b0;
    end else begin
      ctl_a_r.vld  <= rotating && (9'(cnt_r) < n_eff);
      ctl_a_r.last <= rotating && (cnt_r == CNT_LAST);
    end
    ctl_a_r.radius <= balls[0].radius;
    ax_r <= COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
    ay_r <= COORD_BITS'(dy[COORD_BITS] ? -dy : dy);
    az_r <= COORD_BITS'(dz[COORD_BITS] ? -dz : dz);
  end

  // stage b: squares
  logic [SQ_W-1:0] sx_r, sy_r, sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r.vld  <= 1'b0;
      ctl_b_r.last <= 1'b0;
    end else begin
      ctl_b_r.vld  <= ctl_a_r.vld;
      ctl_b_r.last <= ctl_a_r.last;
    end
    ctl_b_r.radius <= ctl_a_r.radius;
    sx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r <= SQ_W'(az_r) * SQ_W'(az_r);
  end

  // stage c: sum of squares
  logic [SUM_W-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r.vld  <= 1'b0;
      ctl_c_r.last <= 1'b0;
    end else begin
      ctl_c_r.vld  <= ctl_b_r.vld;
      ctl_c_r.last <= ctl_b_r.last;
    end
    ctl_c_r.radius <= ctl_b_r.radius;
    sum_r <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
  end

  // ------------------------------------------------------------------
  // square root chain, one root bit per cell, msb first
  // ------------------------------------------------------------------
  root_t rc [ROOT_W+1];
  assign rc[0] = '{ctl: ctl_c_r, rem: sum_r, q: '0};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    usos_root_cell #(.BIT(ROOT_W - 1 - g)) u_root (
      .clk   (clk),
      .rst_n (rst_n),
      .din   (rc[g]),
      .dout  (rc[g+1])
    );
  end

  // ------------------------------------------------------------------
  // radius minus distance and running max
  // ------------------------------------------------------------------
  logic signed [LEVEL_BITS-1:0] v, best_r;
  logic seen_r, done_r, take;

  assign v    = signed'(LEVEL_BITS'(rc[ROOT_W].ctl.radius)) -
                signed'(LEVEL_BITS'(rc[ROOT_W].q));
  assign take = rc[ROOT_W].ctl.vld && (!seen_r || v > best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= rc[ROOT_W].ctl.last;
      if (eval_fire) begin
        seen_r <= 1'b0;
      end else if (rc[ROOT_W].ctl.vld) begin
        seen_r <= 1'b1;
      end
    end
    if (take) begin
      best_r <= v;
    end
  end

  // ------------------------------------------------------------------
  // sequencer and output register
  // ------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt, out_load, out_free;
  logic signed [LEVEL_BITS-1:0] out_level_r;
  logic out_empty_r;

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (eval_fire) begin
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done_r) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (eval_fire) begin
      px_r <= in_x_coord;
      py_r <= in_y_coord;
      pz_r <= in_z_coord;
    end
    if (out_load) begin
      out_level_r <= seen_r ? best_r : LEVEL_MOST_NEG;
      out_empty_r <= ~seen_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level_value = out_level_r;
  assign out_empty_flag  = out_empty_r;

`ifndef ASSERT_OFF
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == ST_DRAIN)
    else $error("result completed outside drain");

  a_rotate_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROTATE && cnt_r == CNT_LAST) |=> state_r == ST_DRAIN)
    else $error("rotation did not end after a full turn");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_flag) |-> out_level_value == LEVEL_MOST_NEG)
    else $error("empty result without most negative value");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");
`endif

endmodule

>>> hdl/usos_ball_cell.sv
// one table cell of the rotating ball chain
module usos_ball_cell (
  input  logic           clk,
  input  logic           load_en,
  input  logic           shift_en,
  input  usos_pkg::ball_t load_ball,
  input  usos_pkg::ball_t next_ball,
  output usos_pkg::ball_t ball
);
  import usos_pkg::*;

  ball_t ball_r;
  ball_t ball_nxt;

  always_comb begin
    ball_nxt = ball_r;
    if (load_en) begin
      ball_nxt = load_ball;
    end else if (shift_en) begin
      ball_nxt = next_ball;
    end
  end

  always_ff @(posedge clk) begin
    ball_r <= ball_nxt;
  end

  assign ball = ball_r;

endmodule

>>> hdl/usos_root_cell.sv
// one bit of the pipelined integer square root
module usos_root_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  usos_pkg::root_t din,
  output usos_pkg::root_t dout
);
  import usos_pkg::*;

  localparam int TW = SUM_W + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_ext;
  logic          fits;
  root_t         st_r;
  root_t         st_nxt;

  // (q + 2^k)^2 - q^2 = q * 2^(k+1) + 2^(2k)
  assign trial   = (TW'(din.q) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign rem_ext = TW'(din.rem);
  assign fits    = (rem_ext >= trial);

  always_comb begin
    st_nxt = din;
    if (fits) begin
      st_nxt.rem = SUM_W'(rem_ext - trial);
      st_nxt.q   = din.q | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ctl.vld  <= 1'b0;
      st_r.ctl.last <= 1'b0;
    end else begin
      st_r.ctl.vld  <= st_nxt.ctl.vld;
      st_r.ctl.last <= st_nxt.ctl.last;
    end
    st_r.ctl.radius <= st_nxt.ctl.radius;
    st_r.rem        <= st_nxt.rem;
    st_r.q          <= st_nxt.q;
  end

  assign dout = st_r;

endmodule
